// ===== src/dcf_pkg.sv =====
// Shared types and constants of the DMA channel with status flags.
package dcf_pkg;

  // Item kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_XFER  = 2'd2;

  // Register word offsets (reg_offset with the low two bits dropped)
  localparam logic [5:0] WOFS_STATUS  = 6'h00;  // 0x00
  localparam logic [5:0] WOFS_CLEAR   = 6'h01;  // 0x04
  localparam logic [5:0] WOFS_CONTROL = 6'h02;  // 0x08
  localparam logic [5:0] WOFS_COUNT   = 6'h03;  // 0x0C
  localparam logic [5:0] WOFS_PBASE   = 6'h04;  // 0x10
  localparam logic [5:0] WOFS_MBASE   = 6'h05;  // 0x14

  localparam int unsigned CTRL_W = 15;

  // Control bits
  localparam int unsigned C_EN   = 0;
  localparam int unsigned C_TCIE = 1;
  localparam int unsigned C_HTIE = 2;
  localparam int unsigned C_TEIE = 3;
  localparam int unsigned C_DIR  = 4;
  localparam int unsigned C_CIRC = 5;
  localparam int unsigned C_PINC = 6;
  localparam int unsigned C_MINC = 7;

  // Status flag bits
  localparam logic [3:0] F_GLOBAL = 4'h1;
  localparam logic [3:0] F_DONE   = 4'h2;
  localparam logic [3:0] F_HALF   = 4'h4;
  localparam logic [3:0] F_ERROR  = 4'h8;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        beat_valid;
    logic [31:0] source_addr;
    logic [2:0]  source_bytes;
    logic [31:0] dest_addr;
    logic [2:0]  dest_bytes;
  } result_t;

endpackage

// ===== src/dma_channel_with_flags_core.sv =====
// Top level of the single DMA channel with register file and status flags.
//
// One DMA channel with its register file. Every input beat is a register
// read, a register write (1, 2 or 4 bytes merged into the addressed byte
// lanes), a transfer or an ignored kind, each giving exactly one output beat.
// Registers: 0x00 status (global, complete, half, error), 0x04 write-1-to-
// clear, 0x08 control, 0x0C count, 0x10 peripheral base, 0x14 memory base.
// Setting EN latches count and bases into working pointers; a request while
// active with a nonzero count issues one transfer (addresses and byte counts
// in the direction DIR selects), advances the pointers, counts down, raises
// half/complete flags, reloads in circular mode and pulses irq_pulse. The
// bus error for that transfer arrives with the request and stops the channel.
// Rate: one input beat per cycle while not stalled. The state update and
// result are computed in a single pass of logic and land in one result
// register; the input is ready whenever that register is empty or is being
// drained in the same cycle, so a stalled consumer holds off the next beat.
module dma_channel_with_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  reg_offset,
  input  logic [2:0]  access_size,
  input  logic [31:0] write_data,
  input  logic        bus_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_pulse,
  output logic        beat_valid,
  output logic [31:0] source_addr,
  output logic [2:0]  source_bytes,
  output logic [31:0] dest_addr,
  output logic [2:0]  dest_bytes
);
  import dcf_pkg::*;

  logic    take;
  result_t core_res;
  result_t held_res;

  assign take = in_valid && in_ready;

  // register file and transfer engine; state advances on each accepted beat
  dcf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .req_type    (req_type),
    .reg_offset  (reg_offset),
    .access_size (access_size),
    .write_data  (write_data),
    .bus_error   (bus_error),
    .result      (core_res)
  );

  dcf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .din       (core_res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (held_res)
  );

  assign read_data    = held_res.read_data;
  assign irq_pulse    = held_res.irq_pulse;
  assign beat_valid   = held_res.beat_valid;
  assign source_addr  = held_res.source_addr;
  assign source_bytes = held_res.source_bytes;
  assign dest_addr    = held_res.dest_addr;
  assign dest_bytes   = held_res.dest_bytes;

endmodule

// ===== src/dcf_core.sv =====
// Channel regs, enable tracking, transfer engine; one item per cycle on take.
module dcf_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [1:0]      req_type,
  input  logic [7:0]      reg_offset,
  input  logic [2:0]      access_size,
  input  logic [31:0]     write_data,
  input  logic            bus_error,
  output dcf_pkg::result_t result
);
  import dcf_pkg::*;

  logic [3:0]        status_flags,   status_flags_next;
  logic [CTRL_W-1:0] control_word,   control_word_next;
  logic [31:0]       item_count,     item_count_next;
  logic [31:0]       periph_base,    periph_base_next;
  logic [31:0]       mem_base,       mem_base_next;
  logic [31:0]       latched_count,  latched_count_next;
  logic [31:0]       periph_pointer, periph_pointer_next;
  logic [31:0]       mem_pointer,    mem_pointer_next;
  logic              channel_active, channel_active_next;

  logic [5:0]  word_ofs;
  logic [4:0]  lane_sh;
  logic [31:0] lane_msk;
  logic [31:0] put_msk;
  logic [31:0] put_val;
  logic [31:0] rd_word;
  logic [2:0]  pbytes;
  logic [2:0]  mbytes;
  logic [31:0] half_cnt;
  logic [31:0] cnt_dec;
  logic [3:0]  clr_bits;
  logic [CTRL_W-1:0] ctrl_wr;
  logic        fire;

  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    unique case (code)
      2'd0:    size_bytes = 3'd1;
      2'd1:    size_bytes = 3'd2;
      default: size_bytes = 3'd4;
    endcase
  endfunction

  // Byte-lane placement; odd sizes act as one byte
  always_comb begin
    word_ofs = reg_offset[7:2];
    if (access_size == 3'd4) begin
      lane_sh  = 5'd0;
      lane_msk = 32'hFFFF_FFFF;
    end else if (access_size == 3'd2) begin
      lane_sh  = {reg_offset[1], 4'b0000};
      lane_msk = 32'h0000_FFFF;
    end else begin
      lane_sh  = {reg_offset[1:0], 3'b000};
      lane_msk = 32'h0000_00FF;
    end
    put_msk = lane_msk << lane_sh;
    put_val = (write_data << lane_sh) & put_msk;
  end

  always_comb begin
    unique case (word_ofs)
      WOFS_STATUS:  rd_word = {28'd0, status_flags};
      WOFS_CONTROL: rd_word = {{(32-CTRL_W){1'b0}}, control_word};
      WOFS_COUNT:   rd_word = item_count;
      WOFS_PBASE:   rd_word = periph_base;
      WOFS_MBASE:   rd_word = mem_base;
      default:      rd_word = 32'd0;
    endcase
  end

  assign pbytes   = size_bytes(control_word[9:8]);
  assign mbytes   = size_bytes(control_word[11:10]);
  assign half_cnt = latched_count >> 1;
  assign cnt_dec  = item_count - 32'd1;
  assign ctrl_wr  = CTRL_W'((control_word & ~put_msk[CTRL_W-1:0]) | put_val[CTRL_W-1:0]);

  always_comb begin
    clr_bits = put_val[3:0];
    if (clr_bits[0]) begin
      clr_bits = 4'hF;
    end
  end

  always_comb begin
    status_flags_next   = status_flags;
    control_word_next   = control_word;
    item_count_next     = item_count;
    periph_base_next    = periph_base;
    mem_base_next       = mem_base;
    latched_count_next  = latched_count;
    periph_pointer_next = periph_pointer;
    mem_pointer_next    = mem_pointer;
    channel_active_next = channel_active;
    result              = '0;
    fire                = 1'b0;

    case (req_type)
      REQ_READ: begin
        result.read_data = (rd_word >> lane_sh) & lane_msk;
      end
      REQ_WRITE: begin
        unique case (word_ofs)
          WOFS_CLEAR: status_flags_next = status_flags & ~clr_bits;
          WOFS_CONTROL: begin
            control_word_next = ctrl_wr;
            // rising enable latches the working copies
            if (ctrl_wr[C_EN] && !channel_active) begin
              channel_active_next = 1'b1;
              latched_count_next  = item_count;
              periph_pointer_next = periph_base;
              mem_pointer_next    = mem_base;
            end else if (!ctrl_wr[C_EN] && channel_active) begin
              channel_active_next = 1'b0;
            end
          end
          WOFS_COUNT: item_count_next  = (item_count & ~put_msk) | put_val;
          WOFS_PBASE: periph_base_next = (periph_base & ~put_msk) | put_val;
          WOFS_MBASE: mem_base_next    = (mem_base & ~put_msk) | put_val;
          default: ;
        endcase
      end
      REQ_XFER: begin
        if (channel_active && (item_count != 32'd0)) begin
          result.beat_valid = 1'b1;
          if (control_word[C_DIR]) begin
            result.source_addr  = mem_pointer;
            result.source_bytes = mbytes;
            result.dest_addr    = periph_pointer;
            result.dest_bytes   = pbytes;
          end else begin
            result.source_addr  = periph_pointer;
            result.source_bytes = pbytes;
            result.dest_addr    = mem_pointer;
            result.dest_bytes   = mbytes;
          end
          if (bus_error) begin
            status_flags_next        = status_flags | F_GLOBAL | F_ERROR;
            control_word_next[C_EN]  = 1'b0;
            channel_active_next      = 1'b0;
            fire                     = control_word[C_TEIE];
          end else begin
            if (control_word[C_PINC]) begin
              periph_pointer_next = periph_pointer + {29'd0, pbytes};
            end
            if (control_word[C_MINC]) begin
              mem_pointer_next = mem_pointer + {29'd0, mbytes};
            end
            item_count_next = cnt_dec;
            if ((half_cnt != 32'd0) && (cnt_dec == half_cnt)) begin
              status_flags_next = status_flags_next | F_GLOBAL | F_HALF;
              fire = fire | control_word[C_HTIE];
            end
            if (cnt_dec == 32'd0) begin
              status_flags_next = status_flags_next | F_GLOBAL | F_DONE;
              fire = fire | control_word[C_TCIE];
              if (control_word[C_CIRC]) begin
                item_count_next     = latched_count;
                periph_pointer_next = periph_base;
                mem_pointer_next    = mem_base;
              end
            end
          end
          result.irq_pulse = fire;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_flags   <= '0;
      control_word   <= '0;
      item_count     <= '0;
      periph_base    <= '0;
      mem_base       <= '0;
      latched_count  <= '0;
      periph_pointer <= '0;
      mem_pointer    <= '0;
      channel_active <= 1'b0;
    end else if (take) begin
      status_flags   <= status_flags_next;
      control_word   <= control_word_next;
      item_count     <= item_count_next;
      periph_base    <= periph_base_next;
      mem_base       <= mem_base_next;
      latched_count  <= latched_count_next;
      periph_pointer <= periph_pointer_next;
      mem_pointer    <= mem_pointer_next;
      channel_active <= channel_active_next;
    end
  end

endmodule

// ===== src/dcf_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
module dcf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dcf_pkg::result_t din,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output dcf_pkg::result_t dout
);
  import dcf_pkg::*;

  // free when empty or the held beat leaves this cycle
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ===== src/dcf_checker.sv =====
// Port-level checks of the DMA channel top level, bound to it.
module dcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        irq_pulse,
  input logic        beat_valid,
  input logic [31:0] source_addr,
  input logic [2:0]  source_bytes,
  input logic [31:0] dest_addr,
  input logic [2:0]  dest_bytes
);

  // every accepted beat yields a result in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // without a transfer, transfer fields and interrupt are zero
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !beat_valid |-> source_addr == 32'd0 && dest_addr == 32'd0 &&
      source_bytes == 3'd0 && dest_bytes == 3'd0 && !irq_pulse)
    else $error("transfer fields set without a transfer");

  // a transfer carries legal sizes and no read data
  a_beat_sizes: assert property (@(posedge clk) disable iff (rst)
    out_valid && beat_valid |-> read_data == 32'd0 &&
      (source_bytes == 3'd1 || source_bytes == 3'd2 || source_bytes == 3'd4) &&
      (dest_bytes == 3'd1 || dest_bytes == 3'd2 || dest_bytes == 3'd4))
    else $error("bad transfer sizes");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(source_addr) && $stable(dest_addr) && $stable(irq_pulse))
    else $error("stalled result changed");

endmodule

bind dma_channel_with_flags_core dcf_checker u_dcf_checker (.*);

// ===== tb/sv/dma_channel_with_flags_core_tb.sv =====
// Self-checking testbench for the DMA channel core: register traffic and transfer requests.
module dma_channel_with_flags_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcf_pkg::*;

  // Item kind that the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Access widths in bytes
  localparam logic [2:0] ACC_BYTE = 3'd1;
  localparam logic [2:0] ACC_HALF = 3'd2;
  localparam logic [2:0] ACC_WORD = 3'd4;

  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 64;    // receiver hold-off to fill the result register
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 8;

  // Shadow copy of the channel: predicts one result beat per accepted item
  // and checks the block's results against them in order.
  class dma_channel_shadow;
    logic [3:0]  flags;
    logic [14:0] ctrl;
    logic [31:0] count;
    logic [31:0] pbase;
    logic [31:0] mbase;
    logic [31:0] reload_count;
    logic [31:0] pptr;
    logic [31:0] mptr;
    bit          active;
    result_t     expected_beats[$];
    int unsigned error_count;

    function new();
      flags = '0;
      ctrl = '0;
      count = '0;
      pbase = '0;
      mbase = '0;
      reload_count = '0;
      pptr = '0;
      mptr = '0;
      active = 1'b0;
      error_count = 0;
    endfunction

    // Bit position of the addressed lane; odd sizes act as one byte
    function logic [4:0] lane_pos(logic [7:0] off, logic [2:0] size);
      if (size == ACC_WORD) return 5'd0;
      if (size == ACC_HALF) return {off[1], 4'b0};
      return {off[1:0], 3'b0};
    endfunction

    function logic [31:0] width_mask(logic [2:0] size);
      if (size == ACC_WORD) return 32'hFFFF_FFFF;
      if (size == ACC_HALF) return 32'h0000_FFFF;
      return 32'h0000_00FF;
    endfunction

    function logic [31:0] merge_lanes(logic [31:0] old, logic [31:0] val,
                                      logic [7:0] off, logic [2:0] size);
      logic [31:0] m;
      logic [4:0]  sh;
      sh = lane_pos(off, size);
      m = width_mask(size) << sh;
      return (old & ~m) | ((val << sh) & m);
    endfunction

    // PSIZE/MSIZE code to bytes; code 3 is a word as well
    function logic [2:0] unit_bytes(logic [1:0] code);
      if (code == 2'd0) return ACC_BYTE;
      if (code == 2'd1) return ACC_HALF;
      return ACC_WORD;
    endfunction

    function logic [31:0] reg_word(logic [7:0] off);
      case (off[7:2])
        WOFS_STATUS:  return {28'd0, flags};
        WOFS_CONTROL: return {17'd0, ctrl};
        WOFS_COUNT:   return count;
        WOFS_PBASE:   return pbase;
        WOFS_MBASE:   return mbase;
        default:      return 32'd0;
      endcase
    endfunction

    function void reg_store(logic [7:0] off, logic [2:0] size, logic [31:0] data);
      logic [31:0] merged;
      logic [3:0]  clr;
      case (off[7:2])
        WOFS_CLEAR: begin
          // only lane 0 reaches the flags; global clears everything
          merged = merge_lanes(32'd0, data, off, size);
          clr = merged[3:0];
          if ((clr & F_GLOBAL) != 0) clr = 4'hF;
          flags = flags & ~clr;
        end
        WOFS_CONTROL: begin
          merged = merge_lanes({17'd0, ctrl}, data, off, size);
          ctrl = merged[14:0];
          if (ctrl[C_EN] && !active) begin
            active = 1'b1;
            reload_count = count;
            pptr = pbase;
            mptr = mbase;
          end else if (!ctrl[C_EN] && active) begin
            active = 1'b0;
          end
        end
        WOFS_COUNT: count = merge_lanes(count, data, off, size);
        WOFS_PBASE: pbase = merge_lanes(pbase, data, off, size);
        WOFS_MBASE: mbase = merge_lanes(mbase, data, off, size);
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] off, logic [2:0] size,
                            logic [31:0] data, logic err);
      result_t     r;
      logic [14:0] c;
      logic [2:0]  pb;
      logic [2:0]  mb;
      logic [31:0] half;
      bit          fire;
      r = '0;
      c = ctrl;
      case (kind)
        REQ_READ: r.read_data = (reg_word(off) >> lane_pos(off, size)) & width_mask(size);
        REQ_WRITE: reg_store(off, size, data);
        REQ_XFER: begin
          if (active && count != 0) begin
            pb = unit_bytes(c[9:8]);
            mb = unit_bytes(c[11:10]);
            r.beat_valid = 1'b1;
            if (c[C_DIR]) begin
              r.source_addr = mptr;
              r.source_bytes = mb;
              r.dest_addr = pptr;
              r.dest_bytes = pb;
            end else begin
              r.source_addr = pptr;
              r.source_bytes = pb;
              r.dest_addr = mptr;
              r.dest_bytes = mb;
            end
            if (err) begin
              // error stops the channel; pointers and count hold
              flags = flags | F_GLOBAL | F_ERROR;
              ctrl[C_EN] = 1'b0;
              active = 1'b0;
              r.irq_pulse = c[C_TEIE];
            end else begin
              fire = 1'b0;
              if (c[C_PINC]) pptr = pptr + {29'd0, pb};
              if (c[C_MINC]) mptr = mptr + {29'd0, mb};
              count = count - 32'd1;
              half = reload_count >> 1;
              if (half != 0 && count == half) begin
                flags = flags | F_GLOBAL | F_HALF;
                if (c[C_HTIE]) fire = 1'b1;
              end
              if (count == 0) begin
                flags = flags | F_GLOBAL | F_DONE;
                if (c[C_TCIE]) fire = 1'b1;
                if (c[C_CIRC]) begin
                  count = reload_count;
                  pptr = pbase;
                  mptr = mbase;
                end
              end
              r.irq_pulse = fire;
            end
          end
        end
        default: ;
      endcase
      expected_beats.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch: expected %h, actual %h", $time, what, want, got);
        error_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t ns: unexpected result beat: expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("read_data",    want.read_data,    got.read_data);
      compare_field("irq_pulse",    32'(want.irq_pulse),    32'(got.irq_pulse));
      compare_field("beat_valid",   32'(want.beat_valid),   32'(got.beat_valid));
      compare_field("source_addr",  want.source_addr,  got.source_addr);
      compare_field("source_bytes", 32'(want.source_bytes), 32'(got.source_bytes));
      compare_field("dest_addr",    want.dest_addr,    got.dest_addr);
      compare_field("dest_bytes",   32'(want.dest_bytes),   32'(got.dest_bytes));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_READ;
  logic [7:0]  reg_offset = '0;
  logic [2:0]  access_size = ACC_WORD;
  logic [31:0] write_data = '0;
  logic        bus_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        irq_pulse;
  logic        beat_valid;
  logic [31:0] source_addr;
  logic [2:0]  source_bytes;
  logic [31:0] dest_addr;
  logic [2:0]  dest_bytes;

  dma_channel_shadow shadow = new();

  bit idle_on = 1'b1;       // random idling on both sides
  bit hold_off_req = 1'b0;  // asks the receiver for one long hold-off
  int items_sent = 0;       // accepted items, ignored kinds excluded

  dma_channel_with_flags_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .reg_offset   (reg_offset),
    .access_size  (access_size),
    .write_data   (write_data),
    .bus_error    (bus_error),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .irq_pulse    (irq_pulse),
    .beat_valid   (beat_valid),
    .source_addr  (source_addr),
    .source_bytes (source_bytes),
    .dest_addr    (dest_addr),
    .dest_bytes   (dest_bytes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offers one item and holds it until the handshake; the shadow is updated
  // at the accepting edge, then a random gap may follow.
  task automatic send_item(logic [1:0] kind, logic [7:0] off, logic [2:0] size,
                           logic [31:0] data, logic err);
    in_valid <= 1'b1;
    req_type <= kind;
    reg_offset <= off;
    access_size <= size;
    write_data <= data;
    bus_error <= err;
    do @(posedge clk); while (!in_ready);
    shadow.note_item(kind, off, size, data, err);
    if (kind != REQ_UNUSED) items_sent++;
    while (idle_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One byte access, now and then with an odd size code that acts as one
  function automatic logic [2:0] byte_size();
    logic [2:0] odd;
    if ($urandom_range(0, 9) < 7) return ACC_BYTE;
    odd = 3'($urandom_range(3, 7));
    if (odd == ACC_WORD) odd = 3'd0;
    return odd;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFE0 | $urandom_range(0, 31);  // wraps soon
      1:       return 32'($urandom_range(0, 65535)) << 2;
      default: return $urandom;
    endcase
  endfunction

  // Writes one register as a word, two halves or four bytes; the unused
  // data bits carry junk the block has to drop.
  task automatic program_word(logic [5:0] wofs, logic [31:0] val);
    logic [31:0] filler;
    case ($urandom_range(0, 3))
      0: begin
        for (int h = 0; h < 2; h++) begin
          filler = $urandom;
          filler[15:0] = val[16*h +: 16];
          send_item(REQ_WRITE, {wofs, h[0], 1'b0}, ACC_HALF, filler,
                    1'($urandom_range(0, 1)));
        end
      end
      1: begin
        for (int b = 0; b < 4; b++) begin
          filler = $urandom;
          filler[7:0] = val[8*b +: 8];
          send_item(REQ_WRITE, {wofs, b[1:0]}, byte_size(), filler,
                    1'($urandom_range(0, 1)));
        end
      end
      default: send_item(REQ_WRITE, {wofs, 2'b00}, ACC_WORD, val, 1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 8'($urandom), 3'($urandom_range(0, 7)), $urandom,
              1'($urandom_range(0, 1)));
  endtask

  // A well-formed run: stop, program bases and count, enable, then a burst
  // of requests with occasional register traffic and rare bus errors.
  task automatic run_session();
    logic [31:0] ctl_data;
    logic [31:0] n_items;
    int          pick;
    int          n_req;
    ctl_data = $urandom;
    ctl_data[C_EN] = 1'b0;
    send_item(REQ_WRITE, {WOFS_CONTROL, 2'b00}, ACC_WORD, ctl_data, 1'($urandom_range(0, 1)));
    program_word(WOFS_PBASE, pick_addr());
    program_word(WOFS_MBASE, pick_addr());
    pick = $urandom_range(0, 99);
    if (pick < 8) n_items = 32'd0;
    else if (pick < 92) n_items = $urandom_range(1, 12);
    else n_items = $urandom;
    program_word(WOFS_COUNT, n_items);
    ctl_data = $urandom;
    ctl_data[C_EN] = 1'b1;
    send_item(REQ_WRITE, {WOFS_CONTROL, 2'b00}, ACC_WORD, ctl_data, 1'($urandom_range(0, 1)));
    n_req = (n_items > 20) ? 20 : int'(n_items) + $urandom_range(0, 3);
    for (int i = 0; i < n_req; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(REQ_READ, 8'($urandom_range(0, 27)), 3'($urandom_range(0, 7)), $urandom,
                     1'($urandom_range(0, 1)));
        1: send_item(REQ_WRITE, {WOFS_CLEAR, 2'b00}, byte_size(), $urandom,
                     1'($urandom_range(0, 1)));
        default: ;
      endcase
      send_item(REQ_XFER, 8'($urandom), 3'($urandom_range(0, 7)), $urandom,
                $urandom_range(0, 99) < 3);
    end
    send_item(REQ_READ, {WOFS_STATUS, 2'b00}, ACC_WORD, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= !idle_on || $urandom_range(0, 99) >= 35;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      shadow.check_result({read_data, irq_pulse, beat_valid, source_addr, source_bytes,
                           dest_addr, dest_bytes});
    end
  end

  // Watchdog: any handshake on either side restarts the count
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("dma_channel_with_flags_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    bit calm_started;
    calm_started = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of an idle block, a four-beat circular run with half
    // and complete events, flag clearing by lane, a bus error, an idle
    // request, the ignored kind, odd sizes and a wrapping pointer.
    send_item(REQ_READ, {WOFS_STATUS, 2'b00}, ACC_WORD, 32'h0, 1'b0);
    send_item(REQ_READ, 8'hFF, ACC_BYTE, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_WRITE, {WOFS_PBASE, 2'b00}, ACC_WORD, 32'hFFFF_FFFC, 1'b0);
    send_item(REQ_WRITE, {WOFS_MBASE, 2'b00}, ACC_WORD, 32'h2000_0000, 1'b0);
    send_item(REQ_WRITE, {WOFS_COUNT, 2'b00}, ACC_WORD, 32'd4, 1'b0);
    // lane 1 of control: word-sized peripheral and memory units
    send_item(REQ_WRITE, {WOFS_CONTROL, 2'b01}, ACC_BYTE, 32'hFFFF_FF0A, 1'b0);
    // lane 0: enable with all interrupts, circular, both increments
    send_item(REQ_WRITE, {WOFS_CONTROL, 2'b00}, ACC_BYTE, 32'h0000_00EF, 1'b0);
    repeat (5) send_item(REQ_XFER, 8'h00, ACC_WORD, 32'h0, 1'b0);
    send_item(REQ_READ, {WOFS_STATUS, 2'b00}, ACC_HALF, 32'h0, 1'b0);
    send_item(REQ_READ, {WOFS_CONTROL, 2'b10}, ACC_HALF, 32'h0, 1'b0);
    send_item(REQ_WRITE, {WOFS_CLEAR, 2'b00}, ACC_BYTE, 32'h0000_0004, 1'b0);
    send_item(REQ_WRITE, {WOFS_CLEAR, 2'b01}, ACC_BYTE, 32'hFFFF_FFFF, 1'b0);
    send_item(REQ_READ, {WOFS_STATUS, 2'b00}, 3'd0, 32'h0, 1'b0);
    send_item(REQ_WRITE, {WOFS_CLEAR, 2'b00}, ACC_WORD, 32'h0000_0001, 1'b0);
    send_item(REQ_XFER, 8'h00, ACC_WORD, 32'h0, 1'b1);
    send_item(REQ_XFER, 8'h00, ACC_WORD, 32'h0, 1'b1);
    send_item(REQ_UNUSED, 8'hFF, 3'd7, 32'hFFFF_FFFF, 1'b1);
    // every control bit, memory to peripheral, size code 3
    send_item(REQ_WRITE, {WOFS_CONTROL, 2'b00}, ACC_WORD, 32'hFFFF_FFFF, 1'b0);
    send_item(REQ_XFER, 8'h00, ACC_WORD, 32'h0, 1'b0);
    send_item(REQ_READ, {WOFS_COUNT, 2'b11}, 3'd7, 32'h0, 1'b0);
    send_item(REQ_WRITE, {WOFS_COUNT, 2'b10}, ACC_HALF, 32'h0, 1'b0);
    send_item(REQ_WRITE, {WOFS_MBASE, 2'b11}, 3'd5, 32'h0000_00AB, 1'b0);
    send_item(REQ_READ, {WOFS_STATUS, 2'b11}, 3'd3, 32'h0, 1'b0);

    // Random: mostly programmed runs, some raw noise; a calm stretch in the
    // middle starts with the receiver's long hold-off.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!calm_started && items_sent >= 700) begin
        calm_started = 1'b1;
        idle_on = 1'b0;
        hold_off_req = 1'b1;
      end
      if (calm_started && items_sent >= 1100) idle_on = 1'b1;
      if ($urandom_range(0, 99) < 75) run_session();
      else repeat ($urandom_range(1, 6)) send_noise();
    end
    in_valid <= 1'b0;

    while (shadow.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.error_count == 0 && shadow.expected_beats.size() == 0) begin
      $display("dma_channel_with_flags_core_tb: done, clean");
    end else begin
      $display("dma_channel_with_flags_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== dma_channel_with_flags_core.f =====
src/dcf_pkg.sv
src/dcf_core.sv
src/dcf_out_reg.sv
src/dma_channel_with_flags_core.sv
src/dcf_checker.sv
tb/sv/dma_channel_with_flags_core_tb.sv
